// ----- src/fms_pkg.sv -----
// fms_pkg: shared types and constants of the frame mean and deviation block
// used by fms_solver and frame_mean_stddev, no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fms_pkg;

   localparam int DEF_MAX_COUNT    = 1024;
   localparam int DEF_SAMPLE_WIDTH = 16;

   // width of the q8 statistics on the result channel
   localparam int STAT_W        = 24;
   // fraction bits of the mean and of the variance fed to the root
   localparam int FRAC_BITS     = 8;
   localparam int VAR_FRAC_BITS = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_N,
      ST_MUL_S,
      ST_MUL_D,
      ST_DIV_M,
      ST_DIV_V,
      ST_SQRT,
      ST_DONE
   } solve_state_type;

   typedef struct packed {
      logic start;
      logic take;
   } solve_cmd_type;

   typedef struct packed {
      logic ready;
      logic done;
   } solve_status_type;

endpackage

`default_nettype wire

// ----- src/fms_solver.sv -----
// fms_solver: end of frame statistics on one shared add/subtract unit
// shift-add products, restoring division and digit-by-digit square root
// depends on fms_pkg
`timescale 1ns / 1ps
`default_nettype none

module fms_solver #(
   parameter int MAX_COUNT    = fms_pkg::DEF_MAX_COUNT,
   parameter int SAMPLE_WIDTH = fms_pkg::DEF_SAMPLE_WIDTH
) (
   input  wire logic                                            clock,
   input  wire logic                                            reset,
   input  wire fms_pkg::solve_cmd_type                          cmd,
   output fms_pkg::solve_status_type                            status,
   input  wire logic signed [SAMPLE_WIDTH+$clog2(MAX_COUNT+1)-1:0] tot_sum,
   input  wire logic [2*SAMPLE_WIDTH+$clog2(MAX_COUNT+1)-2:0]   tot_sumsq,
   input  wire logic [$clog2(MAX_COUNT+1)-1:0]                  tot_count,
   input  wire logic                                            tot_ovf,
   output logic [$clog2(MAX_COUNT+1)-1:0]                       res_count,
   output logic [fms_pkg::STAT_W-1:0]                           res_mean,
   output logic [fms_pkg::STAT_W-1:0]                           res_stddev,
   output logic                                                 res_ovf
);
   import fms_pkg::*;

   localparam int CNT_W  = $clog2(MAX_COUNT + 1);
   localparam int SUM_W  = SAMPLE_WIDTH + CNT_W;
   localparam int MAG_W  = SUM_W - 1;
   localparam int SQ_W   = 2 * SAMPLE_WIDTH + CNT_W - 1;
   localparam int DIFF_W = SQ_W + CNT_W;
   localparam int DEN_W  = 2 * CNT_W;
   localparam int DVD_W  = 2 * ((DIFF_W + VAR_FRAC_BITS + 1) / 2);
   localparam int RT_W   = DVD_W / 2;
   localparam int RM_W   = (DEN_W + 1 > RT_W + 3) ? DEN_W + 1 : RT_W + 3;
   localparam int U_W    = (DIFF_W > RM_W) ? DIFF_W : RM_W;
   localparam int STEP_W = $clog2(DVD_W);

   solve_state_type state_ff, state_in;

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              ovf_ff, ovf_in;
   logic              neg_ff, neg_in;
   logic [MAG_W-1:0]  mag_ff, mag_in;
   logic [DIFF_W-1:0] acc_ff, acc_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DIFF_W-1:0] mcand_ff, mcand_in;
   logic [MAG_W-1:0]  mplier_ff, mplier_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [RM_W-1:0]   rem_ff, rem_in;
   logic [RT_W-1:0]   root_ff, root_in;
   logic [STAT_W-1:0] mean_ff, mean_in;
   logic [STAT_W-1:0] sd_ff, sd_in;

   logic [U_W-1:0]    alu_a, alu_b;
   logic              alu_sub;
   logic [U_W:0]      alu_res;
   logic              alu_ge;

   logic [SUM_W-1:0]  sum_abs;
   logic [DEN_W-1:0]  divisor;
   logic [RM_W-1:0]   div_rem_sh, sq_rem_sh, sq_trial;
   logic [DVD_W-1:0]  quot_next;
   logic [STAT_W-1:0] mean_mag;
   logic              step_last;

   assign sum_abs    = tot_sum[SUM_W-1] ? (~tot_sum + SUM_W'(1)) : tot_sum;
   assign divisor    = (state_ff == ST_DIV_M) ? DEN_W'(cnt_ff) : den_ff;
   assign div_rem_sh = RM_W'({rem_ff[DEN_W-1:0], dvd_ff[DVD_W-1]});
   assign sq_rem_sh  = {rem_ff[RM_W-3:0], dvd_ff[DVD_W-1 -: 2]};
   assign sq_trial   = RM_W'({root_ff, 2'b01});
   assign step_last  = (step_ff == '0);

   // shared unit operand selection
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      unique case (state_ff) inside
         ST_MUL_N: begin
            alu_a = U_W'(acc_ff);
            alu_b = U_W'(mcand_ff);
         end
         ST_MUL_S: begin
            alu_a   = U_W'(acc_ff);
            alu_b   = U_W'(mcand_ff);
            alu_sub = 1'b1;
         end
         ST_MUL_D: begin
            alu_a = U_W'(den_ff);
            alu_b = U_W'(mcand_ff);
         end
         ST_DIV_M, ST_DIV_V: begin
            alu_a   = U_W'(div_rem_sh);
            alu_b   = U_W'(divisor);
            alu_sub = 1'b1;
         end
         ST_SQRT: begin
            alu_a   = U_W'(sq_rem_sh);
            alu_b   = U_W'(sq_trial);
            alu_sub = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // carry out on a subtract means a >= b
   assign alu_res   = {1'b0, alu_a} + {1'b0, alu_b ^ {U_W{alu_sub}}} + (U_W+1)'(alu_sub);
   assign alu_ge    = alu_res[U_W];
   assign quot_next = {dvd_ff[DVD_W-2:0], alu_ge};
   assign mean_mag  = STAT_W'(quot_next);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (cmd.start) state_in = ST_MUL_N;
         ST_MUL_N: if (step_last) state_in = ST_MUL_S;
         ST_MUL_S: if (step_last) state_in = ST_MUL_D;
         ST_MUL_D: if (step_last) state_in = ST_DIV_M;
         ST_DIV_M: if (step_last) state_in = ST_DIV_V;
         ST_DIV_V: if (step_last) state_in = ST_SQRT;
         ST_SQRT:  if (step_last) state_in = ST_DONE;
         ST_DONE:  if (cmd.take) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cnt_in    = cnt_ff;
      ovf_in    = ovf_ff;
      neg_in    = neg_ff;
      mag_in    = mag_ff;
      acc_in    = acc_ff;
      den_in    = den_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      step_in   = step_ff - STEP_W'(1);
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      mean_in   = mean_ff;
      sd_in     = sd_ff;
      unique case (state_ff) inside
         ST_IDLE: begin
            step_in = step_ff;
            if (cmd.start) begin
               cnt_in    = tot_count;
               ovf_in    = tot_ovf;
               neg_in    = tot_sum[SUM_W-1];
               mag_in    = sum_abs[MAG_W-1:0];
               acc_in    = '0;
               den_in    = '0;
               mcand_in  = DIFF_W'(tot_sumsq);
               mplier_in = MAG_W'(tot_count);
               step_in   = STEP_W'(CNT_W - 1);
            end
         end
         ST_MUL_N, ST_MUL_S, ST_MUL_D: begin
            if (mplier_ff[0]) begin
               if (state_ff == ST_MUL_D) den_in = alu_res[DEN_W-1:0];
               else acc_in = alu_res[DIFF_W-1:0];
            end
            mcand_in  = {mcand_ff[DIFF_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[MAG_W-1:1]};
            if (step_last) begin
               unique case (state_ff) inside
                  ST_MUL_N: begin
                     // n * sum of squares done, now subtract sum squared
                     mcand_in  = DIFF_W'(mag_ff);
                     mplier_in = mag_ff;
                     step_in   = STEP_W'(MAG_W - 1);
                  end
                  ST_MUL_S: begin
                     mcand_in  = DIFF_W'(cnt_ff);
                     mplier_in = MAG_W'(cnt_ff);
                     step_in   = STEP_W'(CNT_W - 1);
                  end
                  default: begin
                     dvd_in  = DVD_W'({mag_ff, {FRAC_BITS{1'b0}}});
                     rem_in  = '0;
                     step_in = STEP_W'(DVD_W - 1);
                  end
               endcase
            end
         end
         ST_DIV_M, ST_DIV_V: begin
            rem_in = alu_ge ? RM_W'(alu_res[U_W-1:0]) : div_rem_sh;
            dvd_in = quot_next;
            if (step_last) begin
               rem_in = '0;
               if (state_ff == ST_DIV_M) begin
                  mean_in = neg_ff ? (~mean_mag + STAT_W'(1)) : mean_mag;
                  dvd_in  = DVD_W'({acc_ff, {VAR_FRAC_BITS{1'b0}}});
                  step_in = STEP_W'(DVD_W - 1);
               end else begin
                  root_in = '0;
                  step_in = STEP_W'(RT_W - 1);
               end
            end
         end
         ST_SQRT: begin
            rem_in  = alu_ge ? RM_W'(alu_res[U_W-1:0]) : sq_rem_sh;
            root_in = {root_ff[RT_W-2:0], alu_ge};
            dvd_in  = {dvd_ff[DVD_W-3:0], 2'b00};
            if (step_last) sd_in = STAT_W'({root_ff[RT_W-2:0], alu_ge});
         end
         default: begin
            step_in = step_ff;
         end
      endcase

      status.ready = (state_ff == ST_IDLE);
      status.done  = (state_ff == ST_DONE);
      res_count    = cnt_ff;
      res_mean     = mean_ff;
      res_stddev   = sd_ff;
      res_ovf      = ovf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      ovf_ff    <= ovf_in;
      neg_ff    <= neg_in;
      mag_ff    <= mag_in;
      acc_ff    <= acc_in;
      den_ff    <= den_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      step_ff   <= step_in;
      dvd_ff    <= dvd_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      mean_ff   <= mean_in;
      sd_ff     <= sd_in;
   end

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_M || state_ff == ST_DIV_V) |-> (RM_W'(divisor) > rem_ff))
      else $error("division remainder not below divisor");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_V) |-> (den_ff != '0))
      else $error("variance divisor is zero");

   a_done_after_root: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == ST_DONE) |-> ($past(state_ff) == ST_SQRT))
      else $error("result ready without square root pass");

endmodule

`default_nettype wire

// ----- src/frame_mean_stddev.sv -----
// frame_mean_stddev: top level, frame accumulators and result register
// depends on fms_pkg and fms_solver
//
// usage: samples arrive on the req_ channel, one request per cycle, with
// req_last_sample high on the final sample of a frame. a request is taken
// at a rising edge with req_valid high and req_stall low. each frame gives
// one response on the rsp_ channel: sample count, mean and population
// standard deviation in q8 (mean truncated toward zero, deviation floored)
// and an overflow flag when the frame held more than MAX_COUNT samples
// (samples past MAX_COUNT are dropped from the statistics)
// throughput: one sample per cycle inside a frame. after the last sample,
// req_stall stays high for one cycle, or until the solver is free, while
// the frame totals move into the solver; the next frame then accumulates
// while the solver works
// the solver works through the products, the mean and variance divisions
// and the square root in turn on its single shared add/subtract unit
// a stalled response holds in the output register; a finished solve then
// waits in the solver, and a further frame end waits behind it
// reset (synchronous) clears the accumulators, the solver and rsp_valid
`timescale 1ns / 1ps
`default_nettype none

module frame_mean_stddev #(
   parameter int MAX_COUNT    = fms_pkg::DEF_MAX_COUNT,
   parameter int SAMPLE_WIDTH = fms_pkg::DEF_SAMPLE_WIDTH
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [SAMPLE_WIDTH-1:0]        req_sample,
   input  wire logic                                  req_last_sample,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [$clog2(MAX_COUNT+1)-1:0]             rsp_sample_count,
   output logic signed [fms_pkg::STAT_W-1:0]          rsp_mean_q8,
   output logic [fms_pkg::STAT_W-1:0]                 rsp_stddev_q8,
   output logic                                       rsp_overflow
);
   import fms_pkg::*;

   localparam int CNT_W = $clog2(MAX_COUNT + 1);
   localparam int SUM_W = SAMPLE_WIDTH + CNT_W;
   localparam int SQ_W  = 2 * SAMPLE_WIDTH + CNT_W - 1;

   // frame accumulators
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [SQ_W-1:0]         sumsq_ff, sumsq_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    ovf_ff, ovf_in;
   // a finished frame is waiting for the solver
   logic                    pend_ff, pend_in;

   logic signed [2*SAMPLE_WIDTH-1:0] sq_prod;
   logic                    req_take;

   solve_cmd_type           cmd;
   solve_status_type        status;
   logic [CNT_W-1:0]        res_count;
   logic [STAT_W-1:0]       res_mean, res_stddev;
   logic                    res_ovf;

   // response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]        rsp_count_ff;
   logic [STAT_W-1:0]       rsp_mean_ff, rsp_sd_ff;
   logic                    rsp_ovf_ff;

   assign req_stall = pend_ff;
   assign req_take  = req_valid && !pend_ff;

   // square of the sample, always non-negative
   assign sq_prod = req_sample * req_sample;

   // hand totals over once the solver is idle, take a result once the
   // response register is free or being emptied
   assign cmd.start = pend_ff && status.ready;
   assign cmd.take  = status.done && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      sum_in   = sum_ff;
      sumsq_in = sumsq_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      pend_in  = pend_ff;
      if (cmd.start) begin
         // solver has latched the totals, start a fresh frame
         sum_in   = '0;
         sumsq_in = '0;
         count_in = '0;
         ovf_in   = 1'b0;
         pend_in  = 1'b0;
      end else if (req_take) begin
         if (count_ff < CNT_W'(MAX_COUNT)) begin
            sum_in   = sum_ff + SUM_W'(req_sample);
            sumsq_in = sumsq_ff + SQ_W'($unsigned(sq_prod));
            count_in = count_ff + CNT_W'(1);
         end else begin
            // frame too long, sample dropped
            ovf_in = 1'b1;
         end
         pend_in = req_last_sample;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.take) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         sumsq_ff     <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         sumsq_ff     <= sumsq_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, loaded only when a result is taken
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         rsp_count_ff <= res_count;
         rsp_mean_ff  <= res_mean;
         rsp_sd_ff    <= res_stddev;
         rsp_ovf_ff   <= res_ovf;
      end
   end

   fms_solver #(
      .MAX_COUNT    (MAX_COUNT),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_solver (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .tot_sum    (sum_ff),
      .tot_sumsq  (sumsq_ff),
      .tot_count  (count_ff),
      .tot_ovf    (ovf_ff),
      .res_count  (res_count),
      .res_mean   (res_mean),
      .res_stddev (res_stddev),
      .res_ovf    (res_ovf)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_count = rsp_count_ff;
   assign rsp_mean_q8      = rsp_mean_ff;
   assign rsp_stddev_q8    = rsp_sd_ff;
   assign rsp_overflow     = rsp_ovf_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_COUNT))
      else $error("sample count beyond frame limit");

   a_ovf_only_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (count_ff == CNT_W'(MAX_COUNT)))
      else $error("overflow flagged on a frame that is not full");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (count_ff == '0 && !ovf_ff && !pend_ff))
      else $error("accumulators not cleared after hand-over");

   a_rsp_from_solver: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(status.done))
      else $error("response raised without a finished solve");

endmodule

`default_nettype wire

// ----- tb/frame_mean_stddev_checker.sv -----
// frame_mean_stddev_checker: watches both channels, predicts each frame result and compares
// depends on fms_pkg for the default sizes and STAT_W, no other files
`timescale 1ns / 1ps

module frame_mean_stddev_checker #(
   parameter int MAX_COUNT    = fms_pkg::DEF_MAX_COUNT,
   parameter int SAMPLE_WIDTH = fms_pkg::DEF_SAMPLE_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]        req_sample,
   input  logic                                  req_last_sample,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic [$clog2(MAX_COUNT+1)-1:0]        rsp_sample_count,
   input  logic signed [fms_pkg::STAT_W-1:0]     rsp_mean_q8,
   input  logic [fms_pkg::STAT_W-1:0]            rsp_stddev_q8,
   input  logic                                  rsp_overflow,
   output int                                    failures,
   output int                                    frames_due,
   output int                                    frames_checked
);

   localparam int CNT_W = $clog2(MAX_COUNT + 1);

   typedef struct packed {
      logic [CNT_W-1:0]            count;
      logic [fms_pkg::STAT_W-1:0]  mean_q8;
      logic [fms_pkg::STAT_W-1:0]  stddev_q8;
      logic                        overflow;
   } frame_stats_type;

   frame_stats_type stats_due[$];

   // running frame totals
   longint          acc_sum;
   longint unsigned acc_sq;
   int unsigned     acc_n;
   bit              acc_ovf;
   int              error_count;

   assign failures = error_count;

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= 40)
         $display("%0t ns: result %0d: %s", $time, frames_checked, what);
   endtask

   // largest r with r*r <= x
   function automatic longint unsigned floor_sqrt(input longint unsigned x);
      longint unsigned r, t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= x)
            r = t;
      end
      return r;
   endfunction

   task automatic fold_sample(input logic signed [SAMPLE_WIDTH-1:0] s, input logic last);
      longint          v;
      longint unsigned mag, n, sum_mag, mean_mag, diff, denom, var_q16;
      frame_stats_type e;
      v = s;
      if (acc_n < MAX_COUNT) begin
         mag = (v < 0) ? -v : v;
         acc_sum += v;
         acc_sq  += mag * mag;
         acc_n++;
      end else begin
         acc_ovf = 1'b1;
      end
      if (last) begin
         n        = acc_n;
         sum_mag  = (acc_sum < 0) ? -acc_sum : acc_sum;
         mean_mag = (sum_mag * 64'd256) / n;
         // n^2 * variance, then the q16 quotient with its fraction
         diff     = n * acc_sq - sum_mag * sum_mag;
         denom    = n * n;
         var_q16  = ((diff / denom) << 16) + (((diff % denom) << 16) / denom);
         e.count     = CNT_W'(n);
         e.mean_q8   = fms_pkg::STAT_W'((acc_sum < 0) ? -mean_mag : mean_mag);
         e.stddev_q8 = fms_pkg::STAT_W'(floor_sqrt(var_q16));
         e.overflow  = acc_ovf;
         stats_due.push_back(e);
         acc_sum = 0;
         acc_sq  = 0;
         acc_n   = 0;
         acc_ovf = 1'b0;
      end
   endtask

   task automatic check_result();
      frame_stats_type e;
      if (stats_due.size() == 0) begin
         report_mismatch("response with no frame pending");
      end else begin
         e = stats_due.pop_front();
         if (rsp_sample_count !== e.count)
            report_mismatch($sformatf("sample_count %0d, expected %0d",
                                      rsp_sample_count, e.count));
         if (rsp_mean_q8 !== e.mean_q8)
            report_mismatch($sformatf("mean_q8 %0d, expected %0d",
                                      rsp_mean_q8, $signed(e.mean_q8)));
         if (rsp_stddev_q8 !== e.stddev_q8)
            report_mismatch($sformatf("stddev_q8 %0d, expected %0d",
                                      rsp_stddev_q8, e.stddev_q8));
         if (rsp_overflow !== e.overflow)
            report_mismatch($sformatf("overflow %0b, expected %0b",
                                      rsp_overflow, e.overflow));
      end
      frames_checked++;
   endtask

   initial begin
      error_count    = 0;
      frames_checked = 0;
      frames_due     = 0;
      acc_sum        = 0;
      acc_sq         = 0;
      acc_n          = 0;
      acc_ovf        = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         stats_due.delete();
         acc_sum = 0;
         acc_sq  = 0;
         acc_n   = 0;
         acc_ovf = 1'b0;
      end else begin
         // responses first, a result can never belong to this edge's request
         if (rsp_valid && !rsp_stall)
            check_result();
         if (req_valid && !req_stall)
            fold_sample(req_sample, req_last_sample);
      end
      frames_due <= stats_due.size();
   end

endmodule

// ----- tb/testbench.sv -----
// testbench: stimulus, receiver stalls and verdict for frame_mean_stddev
// depends on fms_pkg, frame_mean_stddev and frame_mean_stddev_checker
`timescale 1ns / 1ps

module testbench;

   localparam int MAX_COUNT    = fms_pkg::DEF_MAX_COUNT;
   localparam int SAMPLE_WIDTH = fms_pkg::DEF_SAMPLE_WIDTH;
   localparam int CNT_W        = $clog2(MAX_COUNT + 1);
   // receiver hold-off long enough for the output register, the solver and
   // the frame totals to back up into req_stall
   localparam int LONG_HOLD    = 2000;
   // margin after the last result for the solver to finish
   localparam int DRAIN_CYCLES = 400;

   // how sample values of a frame are drawn
   typedef enum {FULL_RANGE, EDGE_VALUES, SMALL_VALUES} sample_mix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              req_valid       = 1'b0;
   logic                              req_stall;
   logic signed [SAMPLE_WIDTH-1:0]    req_sample      = '0;
   logic                              req_last_sample = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_stall       = 1'b0;
   logic [CNT_W-1:0]                  rsp_sample_count;
   logic signed [fms_pkg::STAT_W-1:0] rsp_mean_q8;
   logic [fms_pkg::STAT_W-1:0]        rsp_stddev_q8;
   logic                              rsp_overflow;

   int failures;
   int frames_due;
   int frames_checked;

   // idling percentages of the current phase
   int gap_pct   = 0;
   int stall_pct = 0;

   // long hold requests, the receiver serves each one once
   int hold_orders = 0;
   int hold_served = 0;
   int hold_left   = 0;

   int samples_sent = 0;
   int frames_sent  = 0;

   always #1 clock = ~clock;

   frame_mean_stddev #(
      .MAX_COUNT    (MAX_COUNT),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .req_last_sample  (req_last_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_count (rsp_sample_count),
      .rsp_mean_q8      (rsp_mean_q8),
      .rsp_stddev_q8    (rsp_stddev_q8),
      .rsp_overflow     (rsp_overflow)
   );

   frame_mean_stddev_checker #(
      .MAX_COUNT    (MAX_COUNT),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .req_last_sample  (req_last_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_count (rsp_sample_count),
      .rsp_mean_q8      (rsp_mean_q8),
      .rsp_stddev_q8    (rsp_stddev_q8),
      .rsp_overflow     (rsp_overflow),
      .failures         (failures),
      .frames_due       (frames_due),
      .frames_checked   (frames_checked)
   );

   // receiver: random stalls per phase, or a long hold when one is ordered
   always @(posedge clock) begin
      if (hold_served != hold_orders) begin
         hold_served <= hold_orders;
         hold_left   <= LONG_HOLD;
         rsp_stall   <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // offer one request and hold it until the block takes it; gaps only go
   // in before the request, so valid is never dropped and raised in one step
   task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] s, input logic last);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_sample      <= s;
      req_last_sample <= last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      samples_sent++;
      if (last)
         frames_sent++;
   endtask

   function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample(input sample_mix_type mix);
      logic signed [SAMPLE_WIDTH-1:0] s;
      // now and then a full range value, whatever the mix
      if ($urandom_range(9) == 0)
         mix = FULL_RANGE;
      case (mix)
         FULL_RANGE: begin
            s = SAMPLE_WIDTH'($urandom);
         end
         EDGE_VALUES: begin
            case ($urandom_range(4))
               0:       s = 16'sh7FFF;
               1:       s = 16'sh8000;
               2:       s = 16'sh0000;
               3:       s = -16'sd1;
               default: s = 16'sd1;
            endcase
         end
         default: begin
            s = SAMPLE_WIDTH'($urandom_range(16) - 8);
         end
      endcase
      return s;
   endfunction

   task automatic send_frame(input int len, input sample_mix_type mix);
      for (int i = 0; i < len; i++)
         send_sample(pick_sample(mix), i == len - 1);
   endtask

   // mostly short frames, a few long ones
   function automatic int pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 60)
         return $urandom_range(6, 1);
      else if (r < 92)
         return $urandom_range(32, 7);
      else
         return $urandom_range(160, 33);
   endfunction

   task automatic run_phase(input int gap, input int stall, input int quota);
      int start;
      gap_pct   = gap;
      stall_pct = stall;
      start     = samples_sent;
      while (samples_sent - start < quota)
         send_frame(pick_length(), sample_mix_type'($urandom_range(2)));
   endtask

   initial begin
      int waited;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed frames, no idling on either side
      // single sample frames at the extremes: mean at its limits, zero deviation
      send_sample(16'sh7FFF, 1'b1);
      send_sample(16'sh8000, 1'b1);
      send_sample(16'sh0000, 1'b1);
      send_sample(-16'sd1, 1'b1);
      // opposite extremes: largest deviation, negative mean of -0.5
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh8000, 1'b1);
      // negative mean with a fraction, truncated toward zero
      send_sample(-16'sd1, 1'b0);
      send_sample(-16'sd2, 1'b0);
      send_sample(-16'sd2, 1'b1);
      // constant frame, deviation exactly zero
      send_sample(16'sd5, 1'b0);
      send_sample(16'sd5, 1'b0);
      send_sample(16'sd5, 1'b1);
      // largest squares
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh8000, 1'b1);
      // fractional mean and deviation, then an integer mean with a large deviation
      send_sample(16'sd1, 1'b0);
      send_sample(16'sd2, 1'b1);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh8000, 1'b1);

      // no idling: one frame longer than MAX_COUNT (the count passes through
      // its full value, the tail is dropped and flagged), then mostly short frames
      gap_pct   = 0;
      stall_pct = 0;
      send_frame(MAX_COUNT + 3, EDGE_VALUES);
      run_phase(0, 0, 200);

      // sender idling, with a long receiver hold at the start so that the
      // block backs up and stalls its input
      hold_orders <= hold_orders + 1;
      run_phase(57, 0, 240);
      // receiver stalling
      run_phase(0, 57, 240);
      // both sides idling
      run_phase(37, 37, 240);

      req_valid <= 1'b0;
      stall_pct = 0;

      // let the last prediction settle, then wait for every result
      @(posedge clock);
      waited = 0;
      while (frames_due != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (frames_due != 0)
         $display("%0d frame results never arrived", frames_due);
      $display("sent %0d samples in %0d frames, checked %0d results", samples_sent,
               frames_sent, frames_checked);
      $display("included one overflowing frame, a long receiver hold and four idling mixes");
      if (failures == 0 && frames_due == 0) begin
         $display("frame_mean_stddev verification clean");
      end else begin
         $display("frame_mean_stddev verification failed");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #10000000;
      $display("frame_mean_stddev verification failed");
      $finish;
   end

endmodule
